FILE: hdl/furxc_pkg.sv
// Package for the framed update receiver: result record, bundles passed between
// the parser, the result queue and the top level, register indexes and reset codes.
// Depends on nothing; every other file refers to it by scoped names.
package furxc_pkg;

   // Kind of a result transaction.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_START_CODE = 3'd0;
   localparam logic [2:0] CSR_END_CODE   = 3'd1;
   localparam logic [2:0] CSR_ACK_CODE   = 3'd2;
   localparam logic [2:0] CSR_NACK_CODE  = 3'd3;

   // Register values after reset.
   localparam logic [7:0] RST_START_CODE = 8'h0F;
   localparam logic [7:0] RST_END_CODE   = 8'hF0;
   localparam logic [7:0] RST_ACK_CODE   = 8'h79;
   localparam logic [7:0] RST_NACK_CODE  = 8'h7F;

   // Most results one received byte can cause.
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] start_code;
      logic [7:0] end_code;
      logic [7:0] ack_code;
      logic [7:0] nack_code;
   } config_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] mem_address;
      logic [7:0]  mem_byte;
      logic [7:0]  reply_byte;
      logic [15:0] frame_target_address;
      logic [7:0]  frame_number;
      logic        last;
   } result_type;

   // Results produced by one byte: how many, and the records in order.
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] res;
   } push_type;

   // Queue status seen by the top level.
   typedef struct packed {
      logic [2:0] fill;
   } queue_status_type;

endpackage

FILE: hdl/furxc_parse.sv
// Frame parser: holds the session and frame state and turns one received byte
// into zero to three result records. Depends on furxc_pkg.
module furxc_parse #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [7:0]            rx_byte,
   input  furxc_pkg::config_type cfg,
   output furxc_pkg::push_type   push
);

   localparam int AW = MEM_ADDR_BITS;

   logic          at_boundary_ff, at_boundary_in;
   logic          session_on_ff, session_on_in;
   logic [8:0]    byte_index_ff, byte_index_in;
   logic [7:0]    frame_length_ff, frame_length_in;
   logic [15:0]   header_address_ff, header_address_in;
   logic [7:0]    frame_xor_ff, frame_xor_in;
   logic [7:0]    record_xor_ff, record_xor_in;
   logic [AW-1:0] write_pointer_ff, write_pointer_in;
   logic [7:0]    accepted_frames_ff, accepted_frames_in;

   logic [AW-1:0] data_addr;
   logic [AW-1:0] end_addr;
   logic [AW-1:0] next_pointer;
   logic [8:0]    data_limit;
   logic [7:0]    frames_plus_one;

   function automatic furxc_pkg::result_type make_result(
      input logic kind, input logic [15:0] addr, input logic [7:0] mbyte,
      input logic [7:0] rbyte, input logic [15:0] target, input logic [7:0] frame,
      input logic last);
      furxc_pkg::result_type r;
      r.kind                 = kind;
      r.mem_address          = addr;
      r.mem_byte             = mbyte;
      r.reply_byte           = rbyte;
      r.frame_target_address = target;
      r.frame_number         = frame;
      r.last                 = last;
      return r;
   endfunction

   assign data_addr       = write_pointer_ff + AW'(byte_index_ff) - AW'(2);
   assign end_addr        = write_pointer_ff + AW'(frame_length_ff) + AW'(1);
   assign next_pointer    = write_pointer_ff + AW'(frame_length_ff) + AW'(2);
   assign data_limit      = 9'(frame_length_ff) + 9'd3;
   assign frames_plus_one = accepted_frames_ff + 8'd1;

   always_comb begin
      at_boundary_in     = at_boundary_ff;
      session_on_in      = session_on_ff;
      byte_index_in      = byte_index_ff;
      frame_length_in    = frame_length_ff;
      header_address_in  = header_address_ff;
      frame_xor_in       = frame_xor_ff;
      record_xor_in      = record_xor_ff;
      write_pointer_in   = write_pointer_ff;
      accepted_frames_in = accepted_frames_ff;
      push               = '0;
      if (go) begin
         if (at_boundary_ff && rx_byte == cfg.start_code) begin
            at_boundary_in = 1'b0;
            session_on_in  = 1'b1;
            push.count     = 2'd1;
            push.res[0]    = make_result(furxc_pkg::KIND_REPLY, 16'd0, 8'd0, cfg.ack_code,
                                         16'd0, accepted_frames_ff, 1'b1);
         end else if (at_boundary_ff && rx_byte == cfg.end_code) begin
            session_on_in      = 1'b0;
            accepted_frames_in = 8'd0;
            push.count         = 2'd1;
            push.res[0]        = make_result(furxc_pkg::KIND_REPLY, 16'd0, 8'd0,
                                             cfg.ack_code, 16'd0, 8'd0, 1'b1);
         end else begin
            at_boundary_in = 1'b0;
            if (byte_index_ff == 9'd0) begin
               frame_length_in   = rx_byte;
               frame_xor_in      = rx_byte;
               record_xor_in     = rx_byte;
               header_address_in = 16'd0;
               byte_index_in     = 9'd1;
            end else if (byte_index_ff == 9'd1) begin
               header_address_in = {rx_byte, 8'd0};
               frame_xor_in      = frame_xor_ff ^ rx_byte;
               byte_index_in     = 9'd2;
            end else if (byte_index_ff == 9'd2) begin
               header_address_in = {header_address_ff[15:8], rx_byte};
               frame_xor_in      = frame_xor_ff ^ rx_byte;
               byte_index_in     = 9'd3;
            end else if (byte_index_ff < data_limit) begin
               frame_xor_in  = frame_xor_ff ^ rx_byte;
               record_xor_in = record_xor_ff ^ rx_byte;
               byte_index_in = byte_index_ff + 9'd1;
               if (session_on_ff) begin
                  push.count  = 2'd1;
                  push.res[0] = make_result(furxc_pkg::KIND_WRITE, 16'(data_addr), rx_byte,
                                            8'd0, header_address_ff, accepted_frames_ff,
                                            1'b1);
               end
            end else begin
               // Checksum byte: the frame ends here whatever the outcome.
               byte_index_in  = 9'd0;
               at_boundary_in = 1'b1;
               if (!session_on_ff) begin
                  accepted_frames_in = 8'd0;
               end else if (frame_xor_ff == rx_byte) begin
                  accepted_frames_in = frames_plus_one;
                  write_pointer_in   = next_pointer;
                  push.count         = 2'd3;
                  push.res[0] = make_result(furxc_pkg::KIND_WRITE, 16'(write_pointer_ff),
                                            frame_length_ff, 8'd0, header_address_ff,
                                            frames_plus_one, 1'b0);
                  push.res[1] = make_result(furxc_pkg::KIND_WRITE, 16'(end_addr),
                                            record_xor_ff, 8'd0, header_address_ff,
                                            frames_plus_one, 1'b0);
                  push.res[2] = make_result(furxc_pkg::KIND_REPLY, 16'd0, 8'd0,
                                            cfg.ack_code, header_address_ff,
                                            frames_plus_one, 1'b1);
               end else begin
                  push.count  = 2'd1;
                  push.res[0] = make_result(furxc_pkg::KIND_REPLY, 16'd0, 8'd0,
                                            cfg.nack_code, header_address_ff,
                                            accepted_frames_ff, 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_boundary_ff     <= 1'b1;
         session_on_ff      <= 1'b0;
         byte_index_ff      <= 9'd0;
         frame_length_ff    <= 8'd0;
         header_address_ff  <= 16'd0;
         frame_xor_ff       <= 8'd0;
         record_xor_ff      <= 8'd0;
         write_pointer_ff   <= '0;
         accepted_frames_ff <= 8'd0;
      end else begin
         at_boundary_ff     <= at_boundary_in;
         session_on_ff      <= session_on_in;
         byte_index_ff      <= byte_index_in;
         frame_length_ff    <= frame_length_in;
         header_address_ff  <= header_address_in;
         frame_xor_ff       <= frame_xor_in;
         record_xor_ff      <= record_xor_in;
         write_pointer_ff   <= write_pointer_in;
         accepted_frames_ff <= accepted_frames_in;
      end
   end

endmodule

FILE: hdl/furxc_rsp_queue.sv
// Four-entry result queue: takes up to three records in one cycle from the
// parser and hands them out one a cycle as they are popped. Depends on furxc_pkg.
module furxc_rsp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  furxc_pkg::push_type          push,
   input  logic                         pop,
   output logic                         head_valid,
   output furxc_pkg::result_type        head,
   output furxc_pkg::queue_status_type  status
);

   furxc_pkg::result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] fill_ff, fill_in;

   assign head_valid  = (fill_ff != 3'd0);
   assign head        = entry_ff[rd_ptr_ff];
   assign status.fill = fill_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      fill_in   = fill_ff + 3'(push.count) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < furxc_pkg::MAX_RESULTS; k++) begin
         if (2'(k) < push.count) begin
            entry_ff[wr_ptr_ff + 2'(k)] <= push.res[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         fill_ff   <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: hdl/framed_update_receiver_xor_check_top.sv
// Framed update receiver with XOR check: top level with input register, parser,
// result queue and configuration registers. Depends on furxc_pkg, furxc_parse, furxc_rsp_queue.
// A byte accepted into the input register is parsed once the queue has room for its
// results, which are written into the result queue and offered from its head.
// Throughput: one byte a cycle while results are taken as fast; a good frame end gives
// three results, which leave one a cycle through the result port when it is not stalled.
// Reset is synchronous and active high; it restores the default codes and a closed session.
module framed_update_receiver_xor_check_top #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [15:0] rsp_mem_address,
   output logic [7:0]  rsp_mem_byte,
   output logic [7:0]  rsp_reply_byte,
   output logic [15:0] rsp_frame_target_address,
   output logic [7:0]  rsp_frame_number,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wr_data
);

   // Configuration registers. Writes to an index beyond the nack code are dropped.
   furxc_pkg::config_type cfg_ff, cfg_in;

   // Input register: holds one received byte until the parser can take it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_take;
   logic       proc_go;

   furxc_pkg::push_type         push;
   furxc_pkg::result_type       head;
   furxc_pkg::queue_status_type q_status;
   logic                        rsp_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            furxc_pkg::CSR_START_CODE: cfg_in.start_code = csr_wr_data;
            furxc_pkg::CSR_END_CODE:   cfg_in.end_code   = csr_wr_data;
            furxc_pkg::CSR_ACK_CODE:   cfg_in.ack_code   = csr_wr_data;
            furxc_pkg::CSR_NACK_CODE:  cfg_in.nack_code  = csr_wr_data;
            default:                   cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code <= furxc_pkg::RST_START_CODE;
         cfg_ff.end_code   <= furxc_pkg::RST_END_CODE;
         cfg_ff.ack_code   <= furxc_pkg::RST_ACK_CODE;
         cfg_ff.nack_code  <= furxc_pkg::RST_NACK_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The parser works on the held byte only when the queue is sure to have room
   // for the largest burst of three records, which holds while at most one waits.
   assign proc_go   = in_valid_ff && (q_status.fill <= 3'd1);
   assign req_stall = in_valid_ff && !proc_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !proc_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   furxc_parse #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .go      (proc_go),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .push    (push)
   );

   // Results of one byte enter the queue together, so the queue never holds part
   // of a byte's results while the parser waits.
   assign rsp_take = rsp_valid && !rsp_stall;

   furxc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_take),
      .head_valid (rsp_valid),
      .head       (head),
      .status     (q_status)
   );

   assign rsp_kind                 = head.kind;
   assign rsp_mem_address          = head.mem_address;
   assign rsp_mem_byte             = head.mem_byte;
   assign rsp_reply_byte           = head.reply_byte;
   assign rsp_frame_target_address = head.frame_target_address;
   assign rsp_frame_number         = head.frame_number;
   assign rsp_last                 = head.last;

   // The queue can never overflow its four entries.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.fill <= 3'd4)
      else $error("result queue holds more than four records");

   // Whole bursts enter the queue, so a lone waiting record closes its byte.
   a_lone_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && q_status.fill == 3'd1) |-> rsp_last)
      else $error("lone queued record is not the last of its byte");

   // A held byte that the parser could not take stays unchanged.
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proc_go) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input byte changed while waiting");

   // Nothing is pushed into the queue unless the parser was given a byte.
   a_push_needs_go: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> proc_go)
      else $error("results produced without a byte to parse");

endmodule

FILE: bench/tb_framed_update_receiver_xor_check_top.sv
// Self-checking bench for the framed update receiver: directed frames, then random
// sessions under several code settings, one of them with a long receiver hold-off.
// Depends on furxc_pkg and framed_update_receiver_xor_check_top only.
`timescale 1ns / 100ps

module tb_framed_update_receiver_xor_check_top;

   localparam int RANDOM_PHASES_BYTES = 66;   // received bytes per random phase
   localparam int SETTLE_CYCLES       = 8;    // margin for a byte in flight to pass the parser
   localparam int HOLD_CYCLES         = 300;  // long receiver hold-off
   localparam int IDLE_PCT            = 21;
   localparam int DIRECTED_ROWS       = 27;

   // One directed received byte.  Rows marked typed carry the single reply that the
   // byte must cause; the other rows are checked against the frame predictor.
   typedef struct packed {
      logic [7:0]  rx;
      logic        typed;
      logic [7:0]  reply;
      logic [15:0] target;
      logic [7:0]  number;
   } directed_row_type;

   localparam directed_row_type DIRECTED_BYTES [DIRECTED_ROWS] = '{
      // End code while no session is open: acknowledged, session stays closed.
      '{8'hF0, 1'b1, furxc_pkg::RST_ACK_CODE, 16'h0000, 8'd0},
      // Start code opens the session.
      '{8'h0F, 1'b1, furxc_pkg::RST_ACK_CODE, 16'h0000, 8'd0},
      // A length byte equal to the start code straight after it is a length of 15.
      '{8'h0F, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h80, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h01, 1'b0, 8'h00, 16'h0000, 8'h00},
      // Fifteen data bytes, with both codes and the extremes inside the frame.
      '{8'h00, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'hFF, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h0F, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'hF0, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h55, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'hAA, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h01, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h80, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h7F, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'hFE, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h12, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h34, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'hC3, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h3C, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h99, 1'b0, 8'h00, 16'h0000, 8'h00},
      // Correct checksum: two header writes and an acknowledge.
      '{8'h31, 1'b0, 8'h00, 16'h0000, 8'h00},
      // Start code repeated: the frame count of the session is kept.
      '{8'h0F, 1'b1, furxc_pkg::RST_ACK_CODE, 16'h0000, 8'd1},
      // Empty frame to the top address with a wrong checksum: refused.
      '{8'h00, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'hFF, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'hFF, 1'b0, 8'h00, 16'h0000, 8'h00},
      '{8'h01, 1'b1, furxc_pkg::RST_NACK_CODE, 16'hFFFF, 8'd1},
      // End code closes the session and clears the count.
      '{8'hF0, 1'b1, furxc_pkg::RST_ACK_CODE, 16'h0000, 8'd0}
   };

   // Block ports.  Every input has a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_mem_address;
   logic [7:0]  rsp_mem_byte;
   logic [7:0]  rsp_reply_byte;
   logic [15:0] rsp_frame_target_address;
   logic [7:0]  rsp_frame_number;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = furxc_pkg::CSR_START_CODE;
   logic [7:0]  csr_wr_data = 8'h00;

   // Receiver state as the bench predicts it.
   furxc_pkg::config_type codes;
   logic        at_frame_start;
   logic        session_open;
   int          frame_pos;
   logic [7:0]  frame_len;
   logic [15:0] frame_addr;
   logic [7:0]  running_xor;
   logic [7:0]  payload_xor;
   logic [15:0] store_ptr;
   logic [7:0]  frame_count;

   // Results caused by the latest byte, and those still owed by the block.
   furxc_pkg::result_type step_results [furxc_pkg::MAX_RESULTS];
   int                    step_count;
   furxc_pkg::result_type pending_results [$];

   int bytes_sent   = 0;
   int results_seen = 0;
   int frames_good  = 0;
   int frames_bad   = 0;
   int fail_count   = 0;

   // Idling and the one long hold-off of the result side.
   int req_idle_pct  = IDLE_PCT;
   int rsp_stall_pct = IDLE_PCT;
   int holds_asked   = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   framed_update_receiver_xor_check_top u_dut (.*);

   always #10 clock = ~clock;

   // Appends one result to those of the current byte, stamped with the frame count
   // as it stands after the byte.
   function automatic void note_result(logic kind, logic [15:0] addr, logic [7:0] mbyte,
                                       logic [7:0] rbyte, logic [15:0] target, logic last);
      step_results[step_count] = '{kind: kind, mem_address: addr, mem_byte: mbyte,
                                   reply_byte: rbyte, frame_target_address: target,
                                   frame_number: frame_count, last: last};
      step_count++;
   endfunction

   // Frame predictor: advances the receiver state by one byte and lists its results.
   task automatic parse_rx_byte(input logic [7:0] rx);
      step_count = 0;
      if (at_frame_start && rx == codes.start_code) begin
         at_frame_start = 1'b0;
         session_open   = 1'b1;
         note_result(furxc_pkg::KIND_REPLY, 16'h0000, 8'h00, codes.ack_code, 16'h0000,
                     1'b1);
      end else if (at_frame_start && rx == codes.end_code) begin
         session_open = 1'b0;
         frame_count  = 8'h00;
         note_result(furxc_pkg::KIND_REPLY, 16'h0000, 8'h00, codes.ack_code, 16'h0000,
                     1'b1);
      end else begin
         at_frame_start = 1'b0;
         if (frame_pos == 0) begin
            frame_len   = rx;
            running_xor = rx;
            payload_xor = rx;
            frame_addr  = 16'h0000;
            frame_pos   = 1;
         end else if (frame_pos == 1) begin
            frame_addr  = {rx, 8'h00};
            running_xor ^= rx;
            frame_pos   = 2;
         end else if (frame_pos == 2) begin
            frame_addr[7:0] = rx;
            running_xor ^= rx;
            frame_pos   = 3;
         end else if (frame_pos < 3 + int'(frame_len)) begin
            // Data bytes go straight to memory just past the length slot.
            running_xor ^= rx;
            payload_xor ^= rx;
            if (session_open)
               note_result(furxc_pkg::KIND_WRITE, store_ptr + 16'(frame_pos - 2), rx,
                           8'h00, frame_addr, 1'b1);
            frame_pos++;
         end else begin
            // Checksum byte closes the frame either way.
            frame_pos      = 0;
            at_frame_start = 1'b1;
            if (!session_open) begin
               frame_count = 8'h00;
            end else if (running_xor == rx) begin
               frame_count = frame_count + 8'd1;
               note_result(furxc_pkg::KIND_WRITE, store_ptr, frame_len, 8'h00, frame_addr,
                           1'b0);
               note_result(furxc_pkg::KIND_WRITE, store_ptr + 16'd1 + 16'(frame_len),
                           payload_xor, 8'h00, frame_addr, 1'b0);
               note_result(furxc_pkg::KIND_REPLY, 16'h0000, 8'h00, codes.ack_code,
                           frame_addr, 1'b1);
               store_ptr = store_ptr + 16'd2 + 16'(frame_len);
               frames_good++;
            end else begin
               note_result(furxc_pkg::KIND_REPLY, 16'h0000, 8'h00, codes.nack_code,
                           frame_addr, 1'b1);
               frames_bad++;
            end
         end
      end
   endtask

   // Offers one byte, idling at random first, and books its results once it is
   // taken.  A typed row books its own reply in place of the predicted one.
   task automatic send_byte(input logic [7:0] rx, input bit typed = 1'b0,
                            input furxc_pkg::result_type typed_res = '0);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      parse_rx_byte(rx);
      if (typed)
         pending_results.push_back(typed_res);
      else
         for (int i = 0; i < step_count; i++)
            pending_results.push_back(step_results[i]);
   endtask

   // A frame length that is not read as a code when the frame starts at a boundary.
   function automatic logic [7:0] pick_frame_length();
      logic [7:0] len;
      do begin
         len = ($urandom_range(9) == 0) ? 8'($urandom_range(40, 7)) : 8'($urandom_range(6));
      end while (at_frame_start && (len == codes.start_code || len == codes.end_code));
      return len;
   endfunction

   task automatic send_frame(input logic [7:0] len, input bit good);
      logic [7:0] sum;
      logic [7:0] rx;
      sum = len;
      send_byte(len);
      repeat (2 + int'(len)) begin
         rx = 8'($urandom);
         sum ^= rx;
         send_byte(rx);
      end
      send_byte(good ? sum : sum ^ 8'($urandom_range(255, 1)));
   endtask

   // Runs a half-received frame to its end with random bytes; the checksum is
   // right about half the time.
   task automatic finish_open_frame();
      while (frame_pos != 0) begin
         if (frame_pos == 3 + int'(frame_len) && $urandom_range(1) == 1)
            send_byte(running_xor);
         else
            send_byte(8'($urandom));
      end
   endtask

   task automatic random_step();
      int pick;
      finish_open_frame();
      pick = $urandom_range(99);
      // Straight after a start code only a frame can follow.
      if (!at_frame_start && pick < 20)
         pick += 20;
      if (pick < 10)
         send_byte(codes.start_code);
      else if (pick < 20)
         send_byte(codes.end_code);
      else if (pick < 62)
         send_frame(pick_frame_length(), 1'b1);
      else if (pick < 82)
         send_frame(pick_frame_length(), 1'b0);
      else if (pick < 94)
         send_byte(8'($urandom_range(15)));
      else
         send_byte(8'($urandom));
   endtask

   // Lets the block run dry: every owed result taken, then a settling wait of SETTLE_CYCLES
   // for a byte that causes no result to pass the parser.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      case (idx)
         furxc_pkg::CSR_START_CODE: codes.start_code = value;
         furxc_pkg::CSR_END_CODE:   codes.end_code   = value;
         furxc_pkg::CSR_ACK_CODE:   codes.ack_code   = value;
         furxc_pkg::CSR_NACK_CODE:  codes.nack_code  = value;
         default: ;
      endcase
   endtask

   // Loads all four codes while the block is idle; a stray write to an unused
   // index may follow and must change nothing.
   task automatic load_codes(input logic [7:0] start_code, input logic [7:0] end_code,
                             input logic [7:0] ack_code, input logic [7:0] nack_code,
                             input bit stray);
      wait_idle();
      write_register(furxc_pkg::CSR_START_CODE, start_code);
      write_register(furxc_pkg::CSR_END_CODE, end_code);
      write_register(furxc_pkg::CSR_ACK_CODE, ack_code);
      write_register(furxc_pkg::CSR_NACK_CODE, nack_code);
      if (stray)
         write_register(3'($urandom_range(7, int'(furxc_pkg::CSR_NACK_CODE) + 1)),
                        8'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random_phase();
      int phase_start;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_PHASES_BYTES)
         random_step();
   endtask

   // Result side: checks each accepted transaction against the oldest owed result,
   // and chooses its stall for the next cycle.  A hold-off asked for by the stimulus
   // keeps the stall high for a long count while bytes keep coming.
   task automatic check_result();
      furxc_pkg::result_type want;
      if (pending_results.size() == 0) begin
         $error("result transaction with none expected: kind %0b address %h byte %h",
                rsp_kind, rsp_mem_address, rsp_mem_byte);
         fail_count++;
      end else begin
         want = pending_results.pop_front();
         results_seen++;
         if (rsp_kind != want.kind) begin
            $error("kind: expected %0b, actual %0b", want.kind, rsp_kind);
            fail_count++;
         end
         if (rsp_mem_address != want.mem_address) begin
            $error("mem_address: expected %h, actual %h", want.mem_address, rsp_mem_address);
            fail_count++;
         end
         if (rsp_mem_byte != want.mem_byte) begin
            $error("mem_byte: expected %h, actual %h", want.mem_byte, rsp_mem_byte);
            fail_count++;
         end
         if (rsp_reply_byte != want.reply_byte) begin
            $error("reply_byte: expected %h, actual %h", want.reply_byte, rsp_reply_byte);
            fail_count++;
         end
         if (rsp_frame_target_address != want.frame_target_address) begin
            $error("frame_target_address: expected %h, actual %h",
                   want.frame_target_address, rsp_frame_target_address);
            fail_count++;
         end
         if (rsp_frame_number != want.frame_number) begin
            $error("frame_number: expected %0d, actual %0d",
                   want.frame_number, rsp_frame_number);
            fail_count++;
         end
         if (rsp_last != want.last) begin
            $error("last: expected %0b, actual %0b", want.last, rsp_last);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_result();
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Main stimulus.
   initial begin
      furxc_pkg::result_type typed_res;
      logic [7:0]            shared_code;

      // The predictor starts where the block comes out of reset.
      codes          = '{start_code: furxc_pkg::RST_START_CODE,
                         end_code: furxc_pkg::RST_END_CODE,
                         ack_code: furxc_pkg::RST_ACK_CODE,
                         nack_code: furxc_pkg::RST_NACK_CODE};
      at_frame_start = 1'b1;
      session_open   = 1'b0;
      frame_pos      = 0;
      frame_len      = 8'h00;
      frame_addr     = 16'h0000;
      running_xor    = 8'h00;
      payload_xor    = 8'h00;
      store_ptr      = 16'h0000;
      frame_count    = 8'h00;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed bytes under the reset codes.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         typed_res = '{kind: furxc_pkg::KIND_REPLY, mem_address: 16'h0000, mem_byte: 8'h00,
                       reply_byte: DIRECTED_BYTES[r].reply,
                       frame_target_address: DIRECTED_BYTES[r].target,
                       frame_number: DIRECTED_BYTES[r].number, last: 1'b1};
         send_byte(DIRECTED_BYTES[r].rx, DIRECTED_BYTES[r].typed, typed_res);
      end

      // Lowest codes for start and acknowledge, highest for end and refusal.
      load_codes(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
      run_random_phase();

      // The mirror setting, run with no idling on either side.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      load_codes(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
      run_random_phase();
      req_idle_pct  = IDLE_PCT;
      rsp_stall_pct = IDLE_PCT;

      // Random codes, a write to an unused index, and a long hold-off on the result
      // side so that the block backs up and stalls its input.
      load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      holds_asked++;
      run_random_phase();

      // Start and end codes equal: at a boundary the start code wins.
      shared_code = 8'($urandom);
      load_codes(shared_code, shared_code, 8'($urandom), 8'($urandom), 1'b0);
      run_random_phase();

      wait_idle();
      $display("Sent %0d bytes under five code settings; %0d result transactions checked.",
               bytes_sent, results_seen);
      $display("Frames accepted: %0d, refused: %0d; one long hold-off backed up the input.",
               frames_good, frames_bad);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog, well beyond the slowest correct run.
   initial begin
      #40ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
